@@ hw/rtl/ale_pkg.sv @@
// Shared types, codes and helpers for the array list engine.
`default_nettype none
package ale_pkg;

  localparam int ALE_DEPTH    = 128;  // default list capacity
  localparam int ALE_POS_W    = 7;
  localparam int ALE_VAL_W    = 32;
  localparam int ALE_CNT_W    = 8;
  localparam int ALE_SCAN_GRP = 8;    // match bits examined per scan cycle
  localparam int ALE_GRP_W    = 3;    // bits of a position inside one group

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_FIND   = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_REM
  } cell_op_t;

  typedef enum logic [1:0] {
    ALE_IDLE,
    ALE_RUN,
    ALE_SCAN
  } ale_state_t;

  typedef struct packed {
    logic [1:0]                  func;
    logic [ALE_POS_W-1:0]        position;
    logic signed [ALE_VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ALE_POS_W-1:0] found_position;
    logic [ALE_CNT_W-1:0] item_count;
    logic                 is_empty;
  } out_word_t;

  // broadcast to every cell
  typedef struct packed {
    cell_op_t             op;
    logic [ALE_POS_W-1:0] pos;
    logic [ALE_VAL_W-1:0] value;
  } cell_ctrl_t;

  // scan unit report
  typedef struct packed {
    logic                 done;
    logic                 found;
    logic [ALE_POS_W-1:0] pos;
  } scan_res_t;

  // lowest set bit of one match group
  function automatic logic [ALE_GRP_W-1:0] ale_first_bit(
    input logic [ALE_SCAN_GRP-1:0] bits
  );
    logic [ALE_GRP_W-1:0] idx;
    idx = '0;
    for (int i = ALE_SCAN_GRP - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = ALE_GRP_W'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ale_cell.sv @@
// One list cell: holds one entry, shifts with its neighbors, compares.
`default_nettype none
module ale_cell #(
  parameter int IDX  = 0,
  parameter int CMPW = 8
) (
  input  wire                          clk,
  input  wire ale_pkg::cell_ctrl_t     ctrl,
  input  wire [ale_pkg::ALE_VAL_W-1:0] left_data,
  input  wire [ale_pkg::ALE_VAL_W-1:0] right_data,
  output logic [ale_pkg::ALE_VAL_W-1:0] entry,
  output logic                          hit
);
  import ale_pkg::*;

  logic [ALE_VAL_W-1:0] entry_r;
  logic [ALE_VAL_W-1:0] entry_nxt;
  logic [CMPW-1:0]      idx_c;
  logic [CMPW-1:0]      pos_c;

  assign idx_c = CMPW'(IDX);
  assign pos_c = CMPW'(ctrl.pos);

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      CELL_INS: begin
        if (idx_c > pos_c) begin
          entry_nxt = left_data;
        end else if (idx_c == pos_c) begin
          entry_nxt = ctrl.value;
        end
      end
      CELL_REM: begin
        if (idx_c >= pos_c) begin
          entry_nxt = right_data;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign hit   = (entry_r == ctrl.value);

endmodule
`default_nettype wire

@@ hw/rtl/ale_scan.sv @@
// Match vector scanner: finds the lowest set bit, one group per cycle.
`default_nettype none
module ale_scan #(
  parameter int DEPTH = ale_pkg::ALE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  load,
  input  wire [DEPTH-1:0]      hits,
  output ale_pkg::scan_res_t   res
);
  import ale_pkg::*;

  localparam int NG = (DEPTH + ALE_SCAN_GRP - 1) / ALE_SCAN_GRP;
  localparam int VW = NG * ALE_SCAN_GRP;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;
  localparam int IW = $clog2(VW);

  logic [VW-1:0]        vec_r;
  logic [GW-1:0]        grp_r;
  logic                 run_r;
  logic [ALE_SCAN_GRP-1:0] low;
  logic                 any_hit;
  logic                 last_grp;
  logic                 done;
  logic [IW-1:0]        idx;

  assign low      = vec_r[ALE_SCAN_GRP-1:0];
  assign any_hit  = |low;
  assign last_grp = (grp_r == GW'(NG - 1));
  assign done     = run_r && (any_hit || last_grp);
  assign idx      = IW'({grp_r, ale_first_bit(low)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      grp_r <= '0;
    end else if (load) begin
      run_r <= 1'b1;
      grp_r <= '0;
    end else if (run_r) begin
      if (done) begin
        run_r <= 1'b0;
      end else begin
        grp_r <= grp_r + GW'(1);
      end
    end
  end

  // payload shift line of match bits
  always_ff @(posedge clk) begin
    if (load) begin
      vec_r <= VW'(hits);
    end else if (run_r && !done) begin
      vec_r <= vec_r >> ALE_SCAN_GRP;
    end
  end

  assign res.done  = done;
  assign res.found = any_hit;
  assign res.pos   = any_hit ? ALE_POS_W'(idx) : '0;

endmodule
`default_nettype wire

@@ hw/rtl/array_list_engine.sv @@
// Top level of the array list engine: cell row, scanner and control.
`default_nettype none
// Bounded ordered list of signed 32-bit entries, held one per cell in a
// row of DEPTH cells. A word is accepted on the clock edge where start is
// high and busy is low; in_data.func picks insert, remove or find.
// Every accepted word yields exactly one result word on out_data, shown
// for a single cycle with out_valid high. The receiver cannot stall, so
// the result is simply dropped onto the port.
// Insert and remove: the whole row shifts at once (each cell at or past
// the position loads from its left or right neighbor or the new value).
// Its result is registered; a next word can be taken while it is shown.
// Find: every cell compares at once, then the match vector is
// scanned 8 cells per cycle from position 0, stopping at the first hit.
// Its result is registered when the scan stops, at the first matching
// group or after the last group when nothing matches, and the next word
// can be taken while it is shown.
// Rejected operations (full list, bad position) leave the list alone
// and report a status code. Unused func codes report ok.
// Reset (rst_n low, synchronous) empties the list; entry contents are
// not cleared since nothing at or above the count is ever read.
module array_list_engine #(
  parameter int DEPTH = ale_pkg::ALE_DEPTH
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire ale_pkg::in_word_t  in_data,
  output logic               out_valid,
  output ale_pkg::out_word_t out_data
);
  import ale_pkg::*;

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int CMPW = (CNTW > ALE_POS_W) ? CNTW : ALE_POS_W;

  ale_state_t state_r, state_nxt;
  in_word_t   cmd_r;
  logic [CNTW-1:0] count_r, count_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_r, out_nxt;

  cell_ctrl_t ctrl;
  logic       scan_load;
  scan_res_t  scan_res;
  status_t    run_status;

  logic [ALE_VAL_W-1:0] entries [DEPTH];
  logic [DEPTH-1:0]     hit_raw;
  logic [DEPTH-1:0]     live;

  logic [CMPW-1:0] pos_c;
  logic [CMPW-1:0] cnt_c;
  logic            is_full;
  logic            accept;

  assign accept  = start && !busy;
  assign pos_c   = CMPW'(cmd_r.position);
  assign cnt_c   = CMPW'(count_r);
  assign is_full = (count_r == CNTW'(DEPTH));

  // checks for the current command
  always_comb begin
    run_status = ST_OK;
    case (func_t'(cmd_r.func))
      FN_INSERT: begin
        if (is_full) begin
          run_status = ST_FULL;
        end else if (pos_c > cnt_c) begin
          run_status = ST_BAD_POS;
        end
      end
      FN_REMOVE: begin
        if (pos_c >= cnt_c) begin
          run_status = ST_BAD_POS;
        end
      end
      default: run_status = ST_OK;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ALE_IDLE: begin
        if (start) begin
          state_nxt = ALE_RUN;
        end
      end
      ALE_RUN: begin
        if (func_t'(cmd_r.func) == FN_FIND) begin
          state_nxt = ALE_SCAN;
        end else begin
          state_nxt = ALE_IDLE;
        end
      end
      ALE_SCAN: begin
        if (scan_res.done) begin
          state_nxt = ALE_IDLE;
        end
      end
      default: state_nxt = ALE_IDLE;
    endcase
  end

  // state outputs: busy, cell broadcast and scanner load
  always_comb begin
    busy       = 1'b1;
    ctrl.op    = CELL_HOLD;
    ctrl.pos   = cmd_r.position;
    ctrl.value = cmd_r.value;
    scan_load  = 1'b0;
    unique case (state_r)
      ALE_IDLE: busy = 1'b0;
      ALE_RUN: begin
        if (run_status == ST_OK) begin
          if (func_t'(cmd_r.func) == FN_INSERT) begin
            ctrl.op = CELL_INS;
          end else if (func_t'(cmd_r.func) == FN_REMOVE) begin
            ctrl.op = CELL_REM;
          end
        end
        scan_load = (func_t'(cmd_r.func) == FN_FIND);
      end
      ALE_SCAN: busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // count and result word
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    if (state_r == ALE_RUN && func_t'(cmd_r.func) != FN_FIND) begin
      if (ctrl.op == CELL_INS) begin
        count_nxt = count_r + CNTW'(1);
      end else if (ctrl.op == CELL_REM) begin
        count_nxt = count_r - CNTW'(1);
      end
      out_valid_nxt          = 1'b1;
      out_nxt.status         = run_status;
      out_nxt.found_position = '0;
      out_nxt.item_count     = ALE_CNT_W'(count_nxt);
      out_nxt.is_empty       = (count_nxt == '0);
    end else if (state_r == ALE_SCAN && scan_res.done) begin
      out_valid_nxt          = 1'b1;
      out_nxt.status         = scan_res.found ? ST_OK : ST_NOT_FOUND;
      out_nxt.found_position = scan_res.pos;
      out_nxt.item_count     = ALE_CNT_W'(count_r);
      out_nxt.is_empty       = (count_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ALE_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data;
    end
    out_r <= out_nxt;
  end

  // the row of cells; only the last end loops back on itself
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [ALE_VAL_W-1:0] left_d;
    logic [ALE_VAL_W-1:0] right_d;

    if (k == 0) begin : g_first
      assign left_d = cmd_r.value;
    end else begin : g_mid_l
      assign left_d = entries[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_d = entries[k];
    end else begin : g_mid_r
      assign right_d = entries[k+1];
    end

    ale_cell #(
      .IDX  (k),
      .CMPW (CMPW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_data  (left_d),
      .right_data (right_d),
      .entry      (entries[k]),
      .hit        (hit_raw[k])
    );

    // only entries below the count take part in a search
    assign live[k] = (CNTW'(k) < count_r);
  end

  ale_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (scan_load),
    .hits  (hit_raw & live),
    .res   (scan_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ sim/array_list_engine_tb.sv @@
// Self-checking testbench for the array list engine: directed table, then random traffic.
`timescale 1ns / 1ps
module array_list_engine_tb;
  import ale_pkg::*;

  localparam int LIST_DEPTH   = ALE_DEPTH;
  localparam int WORDS_PER_PH = 550;      // random words per idle phase
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 300_000;  // generous cap on the whole run

  // random traffic drifts between filling, draining and mixed work
  typedef enum {TREND_GROW, TREND_SHRINK, TREND_MIX} trend_t;

  // one directed row: the word and, where obvious, its expected result
  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t exp;
  } dir_row_t;

  // word in flight: kept for the mismatch message
  typedef struct packed {
    in_word_t  w;
    out_word_t exp;
  } pending_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_data;
  logic      out_valid;
  out_word_t out_data;

  logic [ALE_VAL_W-1:0] shadow_list[$];  // expected list contents, index = position
  pending_t             pending_q[$];    // results still owed by the block
  dir_row_t             dir_rows[$];
  int unsigned          err_cnt;
  int unsigned          cycle_cnt;
  int unsigned          send_idle_pct;

  array_list_engine #(.DEPTH(LIST_DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // one line per mismatch, and a count
  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Shadow of the list: applies one word and returns the result it owes.
  // Full is checked ahead of the position on insert; finds report the
  // lowest hit; func 3 leaves everything alone and reports ok.
  function automatic out_word_t list_apply(in_word_t w);
    out_word_t   r;
    status_t     st;
    logic [6:0]  hit;
    int unsigned cnt;
    st  = ST_OK;
    hit = '0;
    cnt = shadow_list.size();
    case (func_t'(w.func))
      FN_INSERT: begin
        if (cnt >= LIST_DEPTH) begin
          st = ST_FULL;
        end else if (w.position > cnt) begin
          st = ST_BAD_POS;
        end else begin
          shadow_list.insert(w.position, w.value);
        end
      end
      FN_REMOVE: begin
        if (w.position >= cnt) begin
          st = ST_BAD_POS;
        end else begin
          shadow_list.delete(w.position);
        end
      end
      FN_FIND: begin
        st = ST_NOT_FOUND;
        // walk down so the lowest match wins
        for (int k = int'(cnt) - 1; k >= 0; k--) begin
          if (shadow_list[k] == w.value) begin
            st  = ST_OK;
            hit = 7'(k);
          end
        end
      end
      default: ;
    endcase
    r.status         = st;
    r.found_position = hit;
    r.item_count     = 8'(shadow_list.size());
    r.is_empty       = (shadow_list.size() == 0);
    return r;
  endfunction

  task automatic add_row(func_t f, int unsigned pos, logic [ALE_VAL_W-1:0] v,
                         bit typed = 1'b0, status_t st = ST_OK,
                         int unsigned cnt = 0);
    dir_row_t row;
    row.w.func               = f;
    row.w.position           = 7'(pos);
    row.w.value              = v;
    row.typed                = typed;
    row.exp.status           = st;
    row.exp.found_position   = '0;
    row.exp.item_count       = 8'(cnt);
    row.exp.is_empty         = (cnt == 0);
    dir_rows.push_back(row);
  endtask

  // Random gap, then hold start until the word is taken. Exactly one
  // nonblocking write to start per time step.
  task automatic send_word(in_word_t w, bit typed, out_word_t typed_exp);
    pending_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy !== 1'b0);
    p.w   = w;
    p.exp = list_apply(w);
    if (typed) begin
      p.exp = typed_exp;
    end
    pending_q.push_back(p);
  endtask

  // small pool gives duplicates and hits; extremes and full-range fill the rest
  function automatic logic [ALE_VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) begin
      return 32'($signed($urandom_range(15)) - 8);
    end else if (roll < 50) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  // mostly legal positions, biased to both ends; a few anywhere in range
  function automatic logic [6:0] pick_position(int unsigned top);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 6) begin
      return 7'($urandom_range(127));
    end else if (roll < 30) begin
      return '0;
    end else if (roll < 55) begin
      return 7'(top);
    end
    return 7'($urandom_range(top));
  endfunction

  function automatic in_word_t make_word(trend_t tr);
    in_word_t    w;
    int unsigned ins_w;
    int unsigned rem_w;
    int unsigned roll;
    int unsigned cnt;
    cnt = shadow_list.size();
    case (tr)
      TREND_GROW:   begin ins_w = 70; rem_w = 12; end
      TREND_SHRINK: begin ins_w = 12; rem_w = 70; end
      default:      begin ins_w = 40; rem_w = 40; end
    endcase
    roll       = $urandom_range(99);
    w.value    = pick_value();
    w.position = 7'($urandom_range(127));
    if (roll < ins_w) begin
      w.func     = FN_INSERT;
      w.position = pick_position(cnt > 127 ? 127 : cnt);
    end else if (roll < ins_w + rem_w) begin
      w.func     = FN_REMOVE;
      w.position = pick_position(cnt == 0 ? 0 : cnt - 1);
    end else if (roll < 96) begin
      w.func = FN_FIND;
      // search for something stored most of the time
      if (cnt != 0 && $urandom_range(9) < 7) begin
        w.value = shadow_list[$urandom_range(cnt - 1)];
      end
    end else begin
      w.func = FN_NOP;
    end
    return w;
  endfunction

  // results: checked at the edge that ends their single valid cycle
  always @(posedge clk) begin : result_check
    pending_t p;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_q.size() == 0) begin
        flag_error("result word with nothing pending");
      end else begin
        p = pending_q.pop_front();
        if (out_data.status !== p.exp.status ||
            out_data.found_position !== p.exp.found_position ||
            out_data.item_count !== p.exp.item_count ||
            out_data.is_empty !== p.exp.is_empty) begin
          flag_error($sformatf(
            "func %0d pos %0d val %h: got st %0d fp %0d cnt %0d emp %0b, want %0d %0d %0d %0b",
            p.w.func, p.w.position, p.w.value,
            out_data.status, out_data.found_position, out_data.item_count,
            out_data.is_empty, p.exp.status, p.exp.found_position,
            p.exp.item_count, p.exp.is_empty));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    trend_t      trend;
    int unsigned mix_left;
    in_word_t    w;
    err_cnt       = 0;
    cycle_cnt     = 0;
    send_idle_pct = 23;
    trend         = TREND_GROW;
    mix_left      = 0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;

    // Directed rows. Typed ones: empty list, bad positions, the first
    // inserts, a miss, func 3. The rest lean on the shadow list.
    add_row(FN_REMOVE, 0,   32'h0,         1'b1, ST_BAD_POS,   0); // remove from empty
    add_row(FN_FIND,   0,   32'h0,         1'b1, ST_NOT_FOUND, 0); // find on empty
    add_row(FN_INSERT, 1,   32'h5,         1'b1, ST_BAD_POS,   0); // insert past end
    add_row(FN_INSERT, 127, 32'h5,         1'b1, ST_BAD_POS,   0);
    add_row(FN_NOP,    127, 32'hFFFF_FFFF, 1'b1, ST_OK,        0); // unused func code
    add_row(FN_INSERT, 0,   32'h8000_0000, 1'b1, ST_OK,        1); // most negative
    add_row(FN_INSERT, 1,   32'h7FFF_FFFF, 1'b1, ST_OK,        2); // append, most positive
    add_row(FN_INSERT, 0,   32'hFFFF_FFFF, 1'b1, ST_OK,        3); // front, shifts all
    add_row(FN_INSERT, 3,   32'h0,         1'b1, ST_OK,        4); // append zero
    add_row(FN_INSERT, 2,   32'hFFFF_FFFF);                        // duplicate mid-list
    add_row(FN_FIND,   0,   32'hFFFF_FFFF);                        // lowest of two hits
    add_row(FN_FIND,   0,   32'h7FFF_FFFF);
    add_row(FN_FIND,   0,   32'h0);                                // last entry
    add_row(FN_FIND,   0,   32'd12345,     1'b1, ST_NOT_FOUND, 5); // miss
    add_row(FN_REMOVE, 5,   32'h0,         1'b1, ST_BAD_POS,   5); // remove at count
    add_row(FN_REMOVE, 127, 32'h0,         1'b1, ST_BAD_POS,   5);
    add_row(FN_INSERT, 6,   32'h1,         1'b1, ST_BAD_POS,   5);
    add_row(FN_REMOVE, 0,   32'h0);                                // shifts all down
    add_row(FN_FIND,   0,   32'hFFFF_FFFF);
    add_row(FN_NOP,    0,   32'h0,         1'b1, ST_OK,        4);
    add_row(FN_REMOVE, 3,   32'h0);                                // remove last
    add_row(FN_REMOVE, 0,   32'h0);
    add_row(FN_REMOVE, 0,   32'h0);
    add_row(FN_REMOVE, 0,   32'h0);                                // back to empty
    add_row(FN_FIND,   0,   32'h8000_0000, 1'b1, ST_NOT_FOUND, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].exp);
    end

    // Random part in three idle phases. Traffic fills the list to full,
    // pokes it there (full inserts), drains to empty, mixes, then repeats.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 63 : 0;
      for (int n = 0; n < WORDS_PER_PH; n++) begin
        w = make_word(trend);
        send_word(w, 1'b0, '0);
        case (trend)
          TREND_GROW: begin
            if (shadow_list.size() == LIST_DEPTH && $urandom_range(5) == 0) begin
              trend = TREND_SHRINK;
            end
          end
          TREND_SHRINK: begin
            if (shadow_list.size() == 0 && $urandom_range(3) == 0) begin
              trend    = TREND_MIX;
              mix_left = 80;
            end
          end
          default: begin
            mix_left--;
            if (mix_left == 0) begin
              trend = TREND_GROW;
            end
          end
        endcase
      end
    end
    start <= 1'b0;

    // wait out the last results, then a little more for strays
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ale_pkg.sv
hw/rtl/ale_cell.sv
hw/rtl/ale_scan.sv
hw/rtl/array_list_engine.sv
sim/array_list_engine_tb.sv
